// ----- src/brf_pkg.sv -----
package brf_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH    = 3'd0,
        REQ_POP     = 3'd1,
        REQ_PEEK    = 3'd2,
        REQ_DISCARD = 3'd3,
        REQ_COMMIT  = 3'd4,
        REQ_FLUSH   = 3'd5,
        REQ_STATUS  = 3'd6
    } t_req;

    localparam int unsigned LVL_W   = 11;
    localparam int unsigned MOVE_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OFFS_W  = 10;
    localparam int unsigned IDATA_W = 40;
    localparam int unsigned ODATA_W = 72;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [LVL_W-1:0]  contig_write;
        logic [LVL_W-1:0]  contig_read;
        logic [LVL_W-1:0]  space_left;
        logic [LVL_W-1:0]  fill_level;
    } t_status;

endpackage

// ----- src/brf_store.sv -----
module brf_store
    import brf_pkg::*;
#(
    parameter int unsigned AW = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [2**AW];
    logic [BYTE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ----- src/brf_ctrl.sv -----
module brf_ctrl
    import brf_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  t_req                        i_req,
    input  logic [MOVE_W-1:0]           i_move_count,
    input  logic [OFFS_W-1:0]           i_peek_offset,
    output logic                        o_we,
    output logic [$clog2(CAPACITY)-1:0] o_waddr,
    output logic                        o_re,
    output logic [$clog2(CAPACITY)-1:0] o_raddr,
    output logic                        o_rvalid,
    output logic [MOVE_W-1:0]           o_moved,
    output logic [$clog2(CAPACITY):0]   o_wp,
    output logic [$clog2(CAPACITY):0]   o_rp
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned PW = AW + 1;
    localparam int unsigned XW = PW + MOVE_W;

    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [PW-1:0] fill, space;
    logic [XW-1:0] x_count, x_fill, x_space, x_peek, x_disc, x_over;

    assign fill    = r_wp - r_rp;
    assign space   = PW'(CAPACITY) - fill;
    assign x_count = XW'(i_move_count);
    assign x_fill  = XW'(fill);
    assign x_space = XW'(space);
    assign x_peek  = XW'(r_rp) + XW'(i_peek_offset);
    assign x_disc  = (x_count < x_fill) ? x_count : x_fill;
    assign x_over  = x_count - x_space;

    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        o_we     = 1'b0;
        o_re     = 1'b0;
        o_raddr  = r_rp[AW-1:0];
        o_rvalid = 1'b0;
        o_moved  = '0;
        case (i_req)
            REQ_PUSH: begin
                if (fill != PW'(CAPACITY)) begin
                    o_we    = 1'b1;
                    n_wp    = r_wp + PW'(1);
                    o_moved = MOVE_W'(1);
                end
            end
            REQ_POP: begin
                if (fill != '0) begin
                    o_re     = 1'b1;
                    o_rvalid = 1'b1;
                    n_rp     = r_rp + PW'(1);
                    o_moved  = MOVE_W'(1);
                end
            end
            REQ_PEEK: begin
                o_raddr = x_peek[AW-1:0];
                if (XW'(i_peek_offset) < x_fill) begin
                    o_re     = 1'b1;
                    o_rvalid = 1'b1;
                end
            end
            REQ_DISCARD: begin
                n_rp    = r_rp + x_disc[PW-1:0];
                o_moved = x_disc[MOVE_W-1:0];
            end
            REQ_COMMIT: begin
                if (x_count > x_space) begin
                    n_rp = r_rp + x_over[PW-1:0];
                end
                n_wp    = r_wp + x_count[PW-1:0];
                o_moved = i_move_count;
            end
            REQ_FLUSH: begin
                n_wp = '0;
                n_rp = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else if (i_accept) begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    assign o_waddr = r_wp[AW-1:0];
    assign o_wp    = r_wp;
    assign o_rp    = r_rp;

endmodule

// ----- src/brf_stat.sv -----
module brf_stat
    import brf_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic [$clog2(CAPACITY):0] i_wp,
    input  logic [$clog2(CAPACITY):0] i_rp,
    output t_status                   o_status
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned PW = AW + 1;
    localparam int unsigned XW = PW + MOVE_W;

    logic [PW-1:0] fill, space, run_r, run_w, c_rd, c_wr;
    logic [XW-1:0] x_fill, x_space, x_crd, x_cwr;

    assign fill  = i_wp - i_rp;
    assign space = PW'(CAPACITY) - fill;
    assign run_r = PW'(CAPACITY) - PW'(i_rp[AW-1:0]);
    assign run_w = PW'(CAPACITY) - PW'(i_wp[AW-1:0]);
    assign c_rd  = (fill < run_r) ? fill : run_r;
    assign c_wr  = (space < run_w) ? space : run_w;

    assign x_fill  = XW'(fill);
    assign x_space = XW'(space);
    assign x_crd   = XW'(c_rd);
    assign x_cwr   = XW'(c_wr);

    assign o_status.fill_level   = x_fill[LVL_W-1:0];
    assign o_status.space_left   = x_space[LVL_W-1:0];
    assign o_status.contig_read  = x_crd[LVL_W-1:0];
    assign o_status.contig_write = x_cwr[LVL_W-1:0];
    assign o_status.empty        = (fill == '0);
    assign o_status.full         = (fill == PW'(CAPACITY));

endmodule

// ----- src/byte_ring_fifo.sv -----
// Byte FIFO over a circular store of CAPACITY bytes (a power of two).
// Requests arrive on the s_axis channel: tuser carries the request code
// (push, pop, peek, discard, commit, flush, status), tdata the push byte,
// the move count and the peek offset. Every request gives exactly one
// result on m_axis: the byte read (with its valid flag in tuser), the bytes
// moved, and fill, free space, contiguous read/write runs and empty/full.
// Throughput: one request per cycle while m_axis is not stalled. The result
// passes from the input transfer through a holding stage into the output
// register, from which it is offered on m_axis. Pointers are updated and the
// store written or read at the input transfer; the store read data lands
// in a holding stage, and status is formed from the pointers as the result
// moves into the output register.
// Reset clears both pointers and the pipeline valids; the stored bytes are
// not cleared and read as unknown until written.
// When the receiver stalls, the output register holds its result and one
// more request is still taken into the holding stage; s_axis_tready then
// drops until the output transfer completes.
module byte_ring_fifo
    import brf_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // push_byte[7:0], move_count[23:8], peek_offset[33:24], zero pad
    input  logic [IDATA_W-1:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // read_byte[7:0], bytes_moved[23:8], fill_level[34:24], space_left[45:35],
    // contig_read[56:46], contig_write[67:57], empty_flag[68], full_flag[69], pad
    output logic [ODATA_W-1:0] m_axis_tdata,
    // read_valid[0]
    output logic [0:0]         m_axis_tuser
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned PW = AW + 1;

    logic              accept, p_adv;
    logic              we, re, rvalid;
    logic [AW-1:0]     waddr, raddr;
    logic [MOVE_W-1:0] moved;
    logic [PW-1:0]     wp, rp;
    logic [BYTE_W-1:0] rdata;
    t_status           status;

    logic              r_p_valid, r_p_rvalid;
    logic [MOVE_W-1:0] r_p_moved;
    logic              r_o_valid;
    logic [ODATA_W-1:0] r_o_data;
    logic              r_o_user;

    assign p_adv         = r_p_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_p_valid || p_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    brf_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req        (t_req'(s_axis_tuser)),
        .i_move_count (s_axis_tdata[23:8]),
        .i_peek_offset(s_axis_tdata[33:24]),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_re         (re),
        .o_raddr      (raddr),
        .o_rvalid     (rvalid),
        .o_moved      (moved),
        .o_wp         (wp),
        .o_rp         (rp)
    );

    brf_store #(.AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (we && accept),
        .i_waddr(waddr),
        .i_wdata(s_axis_tdata[7:0]),
        .i_re   (re && accept),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // pointers already hold the post-request values of the held item
    brf_stat #(.CAPACITY(CAPACITY)) u_stat (
        .i_wp    (wp),
        .i_rp    (rp),
        .o_status(status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_p_valid <= 1'b1;
            end else if (p_adv) begin
                r_p_valid <= 1'b0;
            end
            if (p_adv) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_rvalid <= rvalid;
            r_p_moved  <= moved;
        end
        if (p_adv) begin
            r_o_user <= r_p_rvalid;
            r_o_data <= {2'b00, status, r_p_moved,
                         r_p_rvalid ? rdata : BYTE_W'(0)};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

endmodule

// ----- src/brf_chk.sv -----
module brf_chk
    import brf_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [ODATA_W-1:0] m_axis_tdata,
    input logic [0:0]         m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_no_out_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result presented straight after reset");

    a_level_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            LVL_W'(m_axis_tdata[34:24] + m_axis_tdata[45:35]) == LVL_W'(CAPACITY))
        else $error("fill and free space disagree");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[68] && m_axis_tdata[69]))
        else $error("empty and full together");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("read byte not zero without a read");

endmodule

bind byte_ring_fifo brf_chk #(.CAPACITY(CAPACITY)) u_brf_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

// ----- bench/tb.sv -----
module tb;
    import brf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP        = 1024;
    localparam int IDX_MASK   = CAP - 1;
    localparam int PTR_MASK   = 2 * CAP - 1;
    localparam int N_ITEMS    = 1850;
    localparam int QUIET_MAX  = 2000;
    localparam int DRAIN_CYC  = 20;
    localparam int HOLD_AT    = 250;
    localparam int HOLD_CYC   = 80;
    localparam int GEN        = 0;
    localparam int PRED       = 1;
    localparam logic [2:0] REQ_SPARE = 3'd7;

    typedef struct packed {
        logic [2:0]        req;
        logic [BYTE_W-1:0] pbyte;
        logic [MOVE_W-1:0] count;
        logic [OFFS_W-1:0] offs;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] rbyte;
        logic              rvalid;
        logic [MOVE_W-1:0] moved;
        t_status           st;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IDATA_W-1:0] s_axis_tdata = '0;
    logic [2:0]         s_axis_tuser = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [ODATA_W-1:0] m_axis_tdata;
    logic [0:0]         m_axis_tuser;

    // two copies of the ring: one steers generation, one predicts at transfer
    logic [7:0] ring_mem [2][CAP];
    bit         ring_seen [2][CAP];
    int         wr_ptr [2];
    int         rd_ptr [2];

    t_item   req_backlog [$];
    t_result results_due [$];
    t_item   cur_item;

    int in_cnt = 0;
    int out_cnt = 0;
    int err_cnt = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_reads = 0;
    int quiet = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    byte_ring_fifo #(.CAPACITY(CAP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int ring_fill(input int s);
        return (wr_ptr[s] - rd_ptr[s]) & PTR_MASK;
    endfunction

    function automatic t_result ring_apply(input int s, input t_item it);
        t_result r;
        int fill;
        int space;
        int n;
        int rrun;
        int wrun;
        r = '0;
        fill = ring_fill(s);
        space = CAP - fill;
        case (it.req)
            REQ_PUSH: begin
                if (space > 0) begin
                    ring_mem[s][wr_ptr[s] & IDX_MASK] = it.pbyte;
                    ring_seen[s][wr_ptr[s] & IDX_MASK] = 1'b1;
                    wr_ptr[s] = (wr_ptr[s] + 1) & PTR_MASK;
                    r.moved = MOVE_W'(1);
                end
            end
            REQ_POP: begin
                if (fill > 0) begin
                    r.rbyte = ring_mem[s][rd_ptr[s] & IDX_MASK];
                    r.rvalid = 1'b1;
                    rd_ptr[s] = (rd_ptr[s] + 1) & PTR_MASK;
                    r.moved = MOVE_W'(1);
                end
            end
            REQ_PEEK: begin
                if (int'(it.offs) < fill) begin
                    r.rbyte = ring_mem[s][(rd_ptr[s] + int'(it.offs)) & IDX_MASK];
                    r.rvalid = 1'b1;
                end
            end
            REQ_DISCARD: begin
                n = (int'(it.count) < fill) ? int'(it.count) : fill;
                rd_ptr[s] = (rd_ptr[s] + n) & PTR_MASK;
                r.moved = n[MOVE_W-1:0];
            end
            REQ_COMMIT: begin
                if (it.count != '0) begin
                    n = int'(it.count);
                    // overwrite: oldest bytes go when the space runs short
                    if (n > space) rd_ptr[s] = (rd_ptr[s] + n - space) & PTR_MASK;
                    wr_ptr[s] = (wr_ptr[s] + n) & PTR_MASK;
                    r.moved = it.count;
                end
            end
            REQ_FLUSH: begin
                wr_ptr[s] = 0;
                rd_ptr[s] = 0;
            end
            default: ;
        endcase
        fill = ring_fill(s);
        space = CAP - fill;
        rrun = CAP - (rd_ptr[s] & IDX_MASK);
        wrun = CAP - (wr_ptr[s] & IDX_MASK);
        r.st.fill_level = fill[LVL_W-1:0];
        r.st.space_left = space[LVL_W-1:0];
        r.st.contig_read = (fill < rrun) ? fill[LVL_W-1:0] : rrun[LVL_W-1:0];
        r.st.contig_write = (space < wrun) ? space[LVL_W-1:0] : wrun[LVL_W-1:0];
        r.st.empty = (fill == 0);
        r.st.full = (fill >= CAP);
        return r;
    endfunction

    // never lets a pop or peek land on a byte that was never stored
    task automatic enqueue_req(input logic [2:0] req, input logic [7:0] b,
                               input logic [15:0] c, input logic [9:0] o);
        t_item it;
        t_result dummy;
        int fill;
        fill = ring_fill(GEN);
        it.req = req;
        it.pbyte = b;
        it.count = c;
        it.offs = o;
        if (req == REQ_POP && fill > 0 && !ring_seen[GEN][rd_ptr[GEN] & IDX_MASK]) begin
            it.req = REQ_DISCARD;
            it.count = 16'd1;
        end
        if (req == REQ_PEEK && int'(o) < fill
                && !ring_seen[GEN][(rd_ptr[GEN] + int'(o)) & IDX_MASK]) begin
            if (fill < CAP) it.offs = fill[OFFS_W-1:0];
            else it.req = REQ_STATUS;
        end
        dummy = ring_apply(GEN, it);
        req_backlog.push_back(it);
    endtask

    task automatic enqueue_random(input int pick);
        int fill;
        logic [7:0] b;
        logic [15:0] c;
        logic [9:0] o;
        fill = ring_fill(GEN);
        b = 8'($urandom);
        c = 16'($urandom);
        o = 10'($urandom);
        if (pick < 35) begin
            enqueue_req(REQ_PUSH, b, c, o);
        end else if (pick < 65) begin
            enqueue_req(REQ_POP, b, c, o);
        end else if (pick < 85) begin
            if (fill > 0 && $urandom_range(0, 3) != 0)
                o = 10'($urandom_range(0, (fill > CAP - 1 ? CAP : fill) - 1));
            enqueue_req(REQ_PEEK, b, c, o);
        end else if (pick < 91) begin
            if ($urandom_range(0, 3) != 0) c = 16'($urandom_range(0, 48));
            enqueue_req(REQ_DISCARD, b, c, o);
        end else if (pick < 96) begin
            if ($urandom_range(0, 7) != 0) c = 16'($urandom_range(0, 24));
            enqueue_req(REQ_COMMIT, b, c, o);
        end else begin
            case ($urandom_range(0, 2))
                0: enqueue_req(REQ_FLUSH, b, c, o);
                1: enqueue_req(REQ_STATUS, b, c, o);
                default: enqueue_req(REQ_SPARE, b, c, o);
            endcase
        end
    endtask

    function automatic int phase_of(input int n);
        if (n < 460) return 0;
        if (n < 920) return 1;
        if (n < 1380) return 2;
        return 3;
    endfunction

    function automatic int send_idle_pct(input int p);
        case (p)
            1: return 88;
            3: return 35;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input int p);
        case (p)
            2: return 88;
            3: return 35;
            default: return 0;
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned e,
                               input int unsigned a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            err_cnt++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_result r;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r = ring_apply(PRED, cur_item);
                results_due.push_back(r);
                in_cnt <= in_cnt + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_backlog.size() > 0
                        && $urandom_range(0, 99) >= send_idle_pct(phase_of(in_cnt))) begin
                    cur_item = req_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'b0, cur_item.offs, cur_item.count, cur_item.pbyte};
                    s_axis_tuser <= cur_item.req;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off while requests keep coming
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && in_cnt >= HOLD_AT) begin
            hold_left <= HOLD_CYC;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result exp;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.rbyte = m_axis_tdata[7:0];
                got.moved = m_axis_tdata[23:8];
                got.st = m_axis_tdata[69:24];
                got.rvalid = m_axis_tuser[0];
                out_cnt <= out_cnt + 1;
                if (got.st.full) n_full <= n_full + 1;
                if (got.st.empty) n_empty <= n_empty + 1;
                if (got.rvalid) n_reads <= n_reads + 1;
                if (results_due.size() == 0) begin
                    $error("result transfer with nothing expected");
                    err_cnt++;
                end else begin
                    exp = results_due.pop_front();
                    check_field("read_byte", exp.rbyte, got.rbyte);
                    check_field("read_valid", exp.rvalid, got.rvalid);
                    check_field("bytes_moved", exp.moved, got.moved);
                    check_field("fill_level", exp.st.fill_level, got.st.fill_level);
                    check_field("space_left", exp.st.space_left, got.st.space_left);
                    check_field("contig_read", exp.st.contig_read, got.st.contig_read);
                    check_field("contig_write", exp.st.contig_write, got.st.contig_write);
                    check_field("empty_flag", exp.st.empty, got.st.empty);
                    check_field("full_flag", exp.st.full, got.st.full);
                end
            end
            m_axis_tready <= (hold_left == 0)
                && ($urandom_range(0, 99) >= recv_stall_pct(phase_of(in_cnt)));
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_MAX) begin
                $display("tb NOT OK");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    initial begin
        int kind;
        int run;
        int k;
        for (int s = 0; s < 2; s++) begin
            wr_ptr[s] = 0;
            rd_ptr[s] = 0;
            for (int i = 0; i < CAP; i++) ring_seen[s][i] = 1'b0;
        end

        enqueue_req(REQ_STATUS, 8'h00, 16'h0000, 10'd0);
        enqueue_req(REQ_POP, 8'h00, 16'h0000, 10'd0);
        enqueue_req(REQ_PEEK, 8'h00, 16'h0000, 10'd0);
        enqueue_req(REQ_PUSH, 8'h00, 16'h0000, 10'd0);
        enqueue_req(REQ_PUSH, 8'hFF, 16'hFFFF, 10'd1023);
        enqueue_req(REQ_PUSH, 8'hA5, 16'h0000, 10'd0);
        enqueue_req(REQ_PEEK, 8'h00, 16'h0000, 10'd2);
        enqueue_req(REQ_PEEK, 8'h00, 16'h0000, 10'd3);
        enqueue_req(REQ_PEEK, 8'h00, 16'h0000, 10'd1023);
        enqueue_req(REQ_POP, 8'h00, 16'h0000, 10'd0);
        enqueue_req(REQ_DISCARD, 8'h00, 16'h0000, 10'd0);
        enqueue_req(REQ_COMMIT, 8'h00, 16'h0000, 10'd0);
        enqueue_req(REQ_SPARE, 8'h00, 16'h0000, 10'd0);
        enqueue_req(REQ_DISCARD, 8'h00, 16'hFFFF, 10'd0);
        enqueue_req(REQ_COMMIT, 8'h00, 16'hFFFF, 10'd0);
        enqueue_req(REQ_PUSH, 8'h3C, 16'h0000, 10'd0);
        enqueue_req(REQ_DISCARD, 8'h00, 16'd1024, 10'd0);
        enqueue_req(REQ_FLUSH, 8'h00, 16'h0000, 10'd0);
        enqueue_req(REQ_PUSH, 8'h5A, 16'h0000, 10'd0);
        enqueue_req(REQ_POP, 8'h00, 16'h0000, 10'd0);
        enqueue_req(REQ_COMMIT, 8'h00, 16'd1024, 10'd0);
        enqueue_req(REQ_DISCARD, 8'h00, 16'd1024, 10'd0);
        enqueue_req(REQ_COMMIT, 8'h00, 16'd1025, 10'd0);
        enqueue_req(REQ_FLUSH, 8'h00, 16'h0000, 10'd0);

        // runs of pushes and pops walk the fill level across its range
        while (req_backlog.size() < N_ITEMS) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: run = $urandom_range(1, 300);
                3, 4:    run = $urandom_range(1, 300);
                9:       run = 1;
                default: run = $urandom_range(8, 40);
            endcase
            for (k = 0; k < run && req_backlog.size() < N_ITEMS; k++) begin
                case (kind)
                    0, 1, 2: enqueue_random($urandom_range(0, 9) == 0 ? 70 : 0);
                    3, 4:    enqueue_random($urandom_range(0, 9) == 0 ? 70 : 40);
                    9:       enqueue_random($urandom_range(85, 99));
                    default: enqueue_random($urandom_range(0, 99));
                endcase
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (req_backlog.size() != 0 || s_axis_tvalid || results_due.size() != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked over four handshake phases",
                 in_cnt, out_cnt);
        $display("results with ring full: %0d, empty: %0d, valid byte reads: %0d",
                 n_full, n_empty, n_reads);
        if (err_cnt == 0 && results_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
